@@ rtl/core/bst_pkg.sv @@
// ----------------------------------------------------------------------------
// bst_pkg
// Shared types, character codes, token kinds and lookup functions for the
// build script tokenizer.
// ----------------------------------------------------------------------------
package bst_pkg;

    localparam int unsigned LEN_W  = 16;
    localparam int unsigned LINE_W = 24;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned KIND_W = 6;

    localparam logic [LEN_W-1:0]  LEN_MAX  = '1;
    localparam logic [LINE_W-1:0] LINE_MAX = '1;

    // characters
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_BANG   = 8'h21;

    // token kinds
    localparam logic [KIND_W-1:0] K_INVALID    = 6'd0;
    localparam logic [KIND_W-1:0] K_IDENT      = 6'd1;
    localparam logic [KIND_W-1:0] K_NUMBER     = 6'd2;
    localparam logic [KIND_W-1:0] K_STRING     = 6'd3;
    localparam logic [KIND_W-1:0] K_COMMENT    = 6'd4;
    localparam logic [KIND_W-1:0] K_NEWLINE    = 6'd5;
    localparam logic [KIND_W-1:0] K_SPACE      = 6'd6;
    localparam logic [KIND_W-1:0] K_TAB        = 6'd7;
    localparam logic [KIND_W-1:0] K_TASK_SPACE = 6'd8;
    localparam logic [KIND_W-1:0] K_TASK_TAB   = 6'd9;
    localparam logic [KIND_W-1:0] K_DOLLAR     = 6'd10;
    localparam logic [KIND_W-1:0] K_LPAR       = 6'd11;
    localparam logic [KIND_W-1:0] K_RPAR       = 6'd12;
    localparam logic [KIND_W-1:0] K_STAR       = 6'd13;
    localparam logic [KIND_W-1:0] K_DOT        = 6'd14;
    localparam logic [KIND_W-1:0] K_LBRACE     = 6'd15;
    localparam logic [KIND_W-1:0] K_RBRACE     = 6'd16;
    localparam logic [KIND_W-1:0] K_SEMI       = 6'd17;
    localparam logic [KIND_W-1:0] K_ASSIGN     = 6'd18;
    localparam logic [KIND_W-1:0] K_COLON      = 6'd19;
    localparam logic [KIND_W-1:0] K_SLASH      = 6'd20;
    localparam logic [KIND_W-1:0] K_PLUS       = 6'd21;
    localparam logic [KIND_W-1:0] K_MINUS      = 6'd22;
    localparam logic [KIND_W-1:0] K_NE         = 6'd23;
    localparam logic [KIND_W-1:0] K_EQEQ       = 6'd24;
    localparam logic [KIND_W-1:0] K_EQ         = 6'd25;
    localparam logic [KIND_W-1:0] K_AT         = 6'd26;
    localparam logic [KIND_W-1:0] K_BANG       = 6'd27;
    localparam logic [KIND_W-1:0] K_LE         = 6'd28;
    localparam logic [KIND_W-1:0] K_LT         = 6'd29;
    localparam logic [KIND_W-1:0] K_GE         = 6'd30;
    localparam logic [KIND_W-1:0] K_GT         = 6'd31;
    localparam logic [KIND_W-1:0] K_ARROW      = 6'd32;

    typedef enum logic [3:0] {
        CLS_NONE,
        CLS_SYMBOL,
        CLS_NUMBER,
        CLS_STR_OPEN,
        CLS_STR_DONE,
        CLS_COMMENT,
        CLS_NEWLINE,
        CLS_SPACE,
        CLS_TAB,
        CLS_TASK_SPACE,
        CLS_TASK_TAB,
        CLS_LIT_OPEN,
        CLS_LIT_DONE,
        CLS_INVALID
    } t_class;

    typedef struct packed {
        logic                 final_tok;
        logic [LEN_W-1:0]     column;
        logic [LINE_W-1:0]    line;
        logic [LEN_W-1:0]     length;
        logic [POS_W-1:0]     start;
        logic [KIND_W-1:0]    kind;
    } t_token;

    // up to two tokens per source byte: a closed token, then the flush
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token t0;
        t_token t1;
    } t_push;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB;
    endfunction

    function automatic logic [KIND_W-1:0] lit1_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CH_DOLLAR: k = K_DOLLAR;
            CH_LPAR:   k = K_LPAR;
            CH_RPAR:   k = K_RPAR;
            CH_STAR:   k = K_STAR;
            CH_DOT:    k = K_DOT;
            CH_LBRACE: k = K_LBRACE;
            CH_RBRACE: k = K_RBRACE;
            CH_SEMI:   k = K_SEMI;
            CH_COLON:  k = K_COLON;
            CH_SLASH:  k = K_SLASH;
            CH_PLUS:   k = K_PLUS;
            CH_MINUS:  k = K_MINUS;
            CH_EQ:     k = K_EQ;
            CH_AT:     k = K_AT;
            CH_BANG:   k = K_BANG;
            CH_LT:     k = K_LT;
            CH_GT:     k = K_GT;
            default:   k = K_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] lit2_kind(input logic [7:0] b);
        logic [KIND_W-1:0] k;
        case (b)
            CH_COLON: k = K_ASSIGN;
            CH_BANG:  k = K_NE;
            CH_EQ:    k = K_EQEQ;
            CH_LT:    k = K_LE;
            CH_GT:    k = K_GE;
            CH_MINUS: k = K_ARROW;
            default:  k = K_INVALID;
        endcase
        return k;
    endfunction

    function automatic logic [KIND_W-1:0] kind_of(input t_class cls, input logic [7:0] first,
                                                  input logic [LEN_W-1:0] len);
        logic [KIND_W-1:0] k;
        unique case (cls) inside
            CLS_SYMBOL:                 k = K_IDENT;
            CLS_NUMBER:                 k = K_NUMBER;
            CLS_STR_OPEN, CLS_STR_DONE: k = K_STRING;
            CLS_COMMENT:                k = K_COMMENT;
            CLS_NEWLINE:                k = K_NEWLINE;
            CLS_SPACE:                  k = K_SPACE;
            CLS_TAB:                    k = K_TAB;
            CLS_TASK_SPACE:             k = K_TASK_SPACE;
            CLS_TASK_TAB:               k = K_TASK_TAB;
            CLS_LIT_OPEN, CLS_LIT_DONE: k = (len >= 16'd2) ? lit2_kind(first) : lit1_kind(first);
            default:                    k = K_INVALID;
        endcase
        return k;
    endfunction

endpackage

@@ rtl/core/bst_lexer.sv @@
// ----------------------------------------------------------------------------
// bst_lexer
// Input register plus one-step scanner: extends or closes the pending token
// and produces up to two finished tokens per byte.
// ----------------------------------------------------------------------------
module bst_lexer (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    input  logic           i_eot,
    output logic           o_busy,
    output bst_pkg::t_push o_push
);

    logic                         r_in_valid;
    logic [7:0]                   r_byte;
    logic                         r_eot;

    bst_pkg::t_class              r_cls,      n_cls;
    logic [7:0]                   r_first,    n_first;
    logic [bst_pkg::POS_W-1:0]    r_start,    n_start;
    logic [bst_pkg::LEN_W-1:0]    r_len,      n_len;
    logic [bst_pkg::LINE_W-1:0]   r_line,     n_line;
    logic [bst_pkg::LEN_W-1:0]    r_col,      n_col;
    logic                         r_dot,      n_dot;
    logic [bst_pkg::POS_W-1:0]    r_pos,      n_pos;
    logic [bst_pkg::LINE_W-1:0]   r_cur_line, n_cur_line;
    logic [bst_pkg::POS_W-1:0]    r_line_st,  n_line_st;
    logic                         r_prev_nl,  n_prev_nl;

    logic                         w_ext;
    logic [bst_pkg::POS_W-1:0]    w_col_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= i_accept;
        end
        if (i_accept) begin
            r_byte <= i_byte;
            r_eot  <= i_eot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls      <= bst_pkg::CLS_NONE;
            r_first    <= '0;
            r_start    <= '0;
            r_len      <= '0;
            r_line     <= bst_pkg::LINE_W'(1);
            r_col      <= '0;
            r_dot      <= 1'b0;
            r_pos      <= '0;
            r_cur_line <= bst_pkg::LINE_W'(1);
            r_line_st  <= '0;
            r_prev_nl  <= 1'b0;
        end else if (r_in_valid) begin
            r_cls      <= n_cls;
            r_first    <= n_first;
            r_start    <= n_start;
            r_len      <= n_len;
            r_line     <= n_line;
            r_col      <= n_col;
            r_dot      <= n_dot;
            r_pos      <= n_pos;
            r_cur_line <= n_cur_line;
            r_line_st  <= n_line_st;
            r_prev_nl  <= n_prev_nl;
        end
    end

    assign w_col_full = r_pos - r_line_st;

    always_comb begin
        n_cls      = r_cls;
        n_first    = r_first;
        n_start    = r_start;
        n_len      = r_len;
        n_line     = r_line;
        n_col      = r_col;
        n_dot      = r_dot;
        n_pos      = r_pos + 1'b1;
        n_cur_line = r_cur_line;
        n_line_st  = r_line_st;
        n_prev_nl  = (r_byte == bst_pkg::CH_NL);
        w_ext      = 1'b0;
        o_push     = '0;

        // can the byte extend the pending token
        case (r_cls)
            bst_pkg::CLS_SYMBOL: begin
                w_ext = bst_pkg::is_alpha(r_byte) || bst_pkg::is_digit(r_byte) ||
                        r_byte == bst_pkg::CH_UNDER;
            end
            bst_pkg::CLS_NUMBER: begin
                if (r_byte == bst_pkg::CH_DOT && !r_dot) begin
                    w_ext = 1'b1;
                    n_dot = 1'b1;
                end else begin
                    w_ext = bst_pkg::is_digit(r_byte);
                end
            end
            bst_pkg::CLS_STR_OPEN: begin
                w_ext = 1'b1;
                if (r_byte == bst_pkg::CH_QUOTE || r_byte == bst_pkg::CH_NL) begin
                    n_cls = bst_pkg::CLS_STR_DONE;
                end
            end
            bst_pkg::CLS_COMMENT: begin
                w_ext = (r_byte != bst_pkg::CH_NL);
            end
            bst_pkg::CLS_SPACE, bst_pkg::CLS_TAB,
            bst_pkg::CLS_TASK_SPACE, bst_pkg::CLS_TASK_TAB: begin
                w_ext = bst_pkg::is_blank(r_byte);
            end
            bst_pkg::CLS_LIT_OPEN: begin
                w_ext = (r_byte == ((r_first == bst_pkg::CH_MINUS) ? bst_pkg::CH_GT
                                                                   : bst_pkg::CH_EQ));
                if (w_ext) begin
                    n_cls = bst_pkg::CLS_LIT_DONE;
                end
            end
            default: begin
                w_ext = 1'b0;
            end
        endcase

        if (w_ext) begin
            if (r_len != bst_pkg::LEN_MAX) begin
                n_len = r_len + 1'b1;
            end
        end else begin
            // close the pending token and open a new one at this byte
            o_push.v0           = (r_cls != bst_pkg::CLS_NONE);
            o_push.t0.kind      = bst_pkg::kind_of(r_cls, r_first, r_len);
            o_push.t0.start     = r_start;
            o_push.t0.length    = r_len;
            o_push.t0.line      = r_line;
            o_push.t0.column    = r_col;
            o_push.t0.final_tok = 1'b0;

            n_start = r_pos;
            n_line  = r_cur_line;
            n_col   = (w_col_full[bst_pkg::POS_W-1:bst_pkg::LEN_W] != '0) ?
                      bst_pkg::LEN_MAX : w_col_full[bst_pkg::LEN_W-1:0];
            n_len   = bst_pkg::LEN_W'(1);
            n_first = r_byte;
            n_dot   = 1'b0;
            if (r_byte == bst_pkg::CH_NL || r_byte == bst_pkg::CH_CR) begin
                n_cls = bst_pkg::CLS_NEWLINE;
            end else if (bst_pkg::is_blank(r_byte)) begin
                if (r_prev_nl) begin
                    n_cls = (r_byte == bst_pkg::CH_TAB) ? bst_pkg::CLS_TASK_TAB
                                                        : bst_pkg::CLS_TASK_SPACE;
                end else begin
                    n_cls = (r_byte == bst_pkg::CH_TAB) ? bst_pkg::CLS_TAB
                                                        : bst_pkg::CLS_SPACE;
                end
            end else if (bst_pkg::is_alpha(r_byte) || r_byte == bst_pkg::CH_UNDER) begin
                n_cls = bst_pkg::CLS_SYMBOL;
            end else if (r_byte == bst_pkg::CH_QUOTE) begin
                n_cls = bst_pkg::CLS_STR_OPEN;
            end else if (bst_pkg::is_digit(r_byte)) begin
                n_cls = bst_pkg::CLS_NUMBER;
            end else if (bst_pkg::lit2_kind(r_byte) != bst_pkg::K_INVALID) begin
                n_cls = bst_pkg::CLS_LIT_OPEN;
            end else if (bst_pkg::lit1_kind(r_byte) != bst_pkg::K_INVALID) begin
                n_cls = bst_pkg::CLS_LIT_DONE;
            end else if (r_byte == bst_pkg::CH_HASH) begin
                n_cls = bst_pkg::CLS_COMMENT;
            end else begin
                n_cls = bst_pkg::CLS_INVALID;
            end
        end

        // only LF moves the line counters
        if (r_byte == bst_pkg::CH_NL) begin
            if (r_cur_line != bst_pkg::LINE_MAX) begin
                n_cur_line = r_cur_line + 1'b1;
            end
            n_line_st = r_pos + 1'b1;
        end

        // end of text: flush the (updated) pending token, then restart
        if (r_eot) begin
            o_push.v1           = 1'b1;
            o_push.t1.kind      = bst_pkg::kind_of(n_cls, n_first, n_len);
            o_push.t1.start     = n_start;
            o_push.t1.length    = n_len;
            o_push.t1.line      = n_line;
            o_push.t1.column    = n_col;
            o_push.t1.final_tok = 1'b1;

            n_cls      = bst_pkg::CLS_NONE;
            n_first    = '0;
            n_start    = '0;
            n_len      = '0;
            n_line     = bst_pkg::LINE_W'(1);
            n_col      = '0;
            n_dot      = 1'b0;
            n_pos      = '0;
            n_cur_line = bst_pkg::LINE_W'(1);
            n_line_st  = '0;
            n_prev_nl  = 1'b0;
        end

        if (!r_in_valid) begin
            o_push.v0 = 1'b0;
            o_push.v1 = 1'b0;
        end
    end

    assign o_busy = r_in_valid;

endmodule

@@ rtl/core/bst_fifo.sv @@
// ----------------------------------------------------------------------------
// bst_fifo
// Token output queue: takes zero, one or two tokens per cycle, hands out one while i_ready is high.
// ----------------------------------------------------------------------------
module bst_fifo #(
    parameter int unsigned DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bst_pkg::t_push             i_push,
    output logic                       o_valid,
    input  logic                       i_ready,
    output bst_pkg::t_token            o_token,
    output logic [$clog2(DEPTH+1)-1:0] o_level
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH+1);

    bst_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;

    logic            w_pop;
    logic            w_wa, w_wb;
    bst_pkg::t_token w_da;
    logic [AW-1:0]   w_tail_1;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == AW'(DEPTH-1)) ? '0 : p + 1'b1;
    endfunction

    // compact the pair so a lone flush lands at the tail
    assign w_wa     = i_push.v0 | i_push.v1;
    assign w_wb     = i_push.v0 & i_push.v1;
    assign w_da     = i_push.v0 ? i_push.t0 : i_push.t1;
    assign w_tail_1 = ptr_inc(r_tail);
    assign w_pop    = (r_count != '0) && i_ready;

    always_comb begin
        n_head  = w_pop ? ptr_inc(r_head) : r_head;
        n_tail  = r_tail;
        if (w_wb) begin
            n_tail = ptr_inc(w_tail_1);
        end else if (w_wa) begin
            n_tail = w_tail_1;
        end
        n_count = r_count + CW'(w_wa) + CW'(w_wb) - CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wa) begin
            r_mem[r_tail] <= w_da;
        end
        if (w_wb) begin
            r_mem[w_tail_1] <= i_push.t1;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_head];
    assign o_level = r_count;

endmodule

@@ rtl/core/build_script_tokenizer.sv @@
// ----------------------------------------------------------------------------
// build_script_tokenizer
// Streaming tokenizer for a build script language, one source byte per item.
// ----------------------------------------------------------------------------
// Slave channel: one source byte per item; s_axis_tlast marks the final byte
//   of a text. Master channel: one token per item; m_axis_tlast is set on the
//   token flushed by the final byte.
// A byte closes the pending token (one result) and, as the final byte, also
//   flushes the token it leaves, so a byte gives zero, one or two tokens.
//   After the final byte all counters return to their reset values.
// Timing: one byte per cycle while s_axis_tready is high. A token reaches the
//   master side through the input register and the output queue.
//   The queue drains one token per cycle while m_axis_tready is high.
// Reset (i_rst_n low, synchronous): queue emptied, no token pending, line 1.
// Receiver stall: tokens wait in the queue. The slave side keeps room for two
//   tokens per byte in flight: tready drops once the queue holds more than
//   FIFO_DEPTH-4 tokens while a byte sits in the input register, or more than
//   FIFO_DEPTH-2 tokens while the input register is empty.
// ----------------------------------------------------------------------------
module build_script_tokenizer #(
    parameter int unsigned FIFO_DEPTH = 8   // output queue entries, >= 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
    input  logic        s_axis_tlast,   // end_of_text

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,   // [5:0] token_kind, [37:6] start_offset,
                                        // [53:38] token_length, [77:54] line_number,
                                        // [93:78] column_number, [95:94] zero
    output logic        m_axis_tlast    // final_token
);

    localparam int unsigned CW = $clog2(FIFO_DEPTH+1);

    logic                w_accept;
    logic                w_busy;
    bst_pkg::t_push      w_push;
    bst_pkg::t_token     w_tok;
    logic [CW-1:0]       w_level;
    logic [CW:0]         w_need;

    // room for the byte in flight and the one offered now
    assign w_need        = {1'b0, w_level} + (w_busy ? (CW+1)'(4) : (CW+1)'(2));
    assign s_axis_tready = (w_need <= (CW+1)'(FIFO_DEPTH));
    assign w_accept      = s_axis_tvalid & s_axis_tready;

    bst_lexer u_lexer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_byte   (s_axis_tdata),
        .i_eot    (s_axis_tlast),
        .o_busy   (w_busy),
        .o_push   (w_push)
    );

    bst_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_token (w_tok),
        .o_level (w_level)
    );

    assign m_axis_tdata = {2'b00, w_tok.column, w_tok.line, w_tok.length,
                           w_tok.start, w_tok.kind};
    assign m_axis_tlast = w_tok.final_tok;

endmodule

@@ tb/build_script_tokenizer_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// build_script_tokenizer_checker
// Watches both channels of the tokenizer, predicts the token stream from the
// accepted source bytes and compares every token that leaves the block.
// ----------------------------------------------------------------------------
module build_script_tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,      // [7:0] source_byte
    input  logic        i_in_last,      // end_of_text

    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [95:0] i_out_data,     // [5:0] kind, [37:6] start, [53:38] length,
                                        // [77:54] line, [93:78] column
    input  logic        i_out_last,     // final_token

    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [bst_pkg::KIND_W-1:0] kind;
        logic [bst_pkg::POS_W-1:0]  start;
        logic [bst_pkg::LEN_W-1:0]  length;
        logic [bst_pkg::LINE_W-1:0] line;
        logic [bst_pkg::LEN_W-1:0]  column;
        logic                       last_tok;
    } t_exp_token;

    // tokenizer state
    bst_pkg::t_class            cls;
    logic [7:0]                 first_ch;
    logic [bst_pkg::POS_W-1:0]  tok_start;
    logic [bst_pkg::LEN_W-1:0]  tok_len;
    logic [bst_pkg::LINE_W-1:0] tok_line;
    logic [bst_pkg::LEN_W-1:0]  tok_col;
    logic                       has_dot;
    logic [bst_pkg::POS_W-1:0]  byte_pos;
    logic [bst_pkg::LINE_W-1:0] cur_line;
    logic [bst_pkg::POS_W-1:0]  line_base;
    logic                       after_nl;

    t_exp_token expected_tokens[$];
    int         fail_count = 0;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
    end

    function automatic logic word_start(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == bst_pkg::CH_UNDER;
    endfunction

    function automatic logic decimal(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic blank_char(input logic [7:0] b);
        return b == bst_pkg::CH_SPACE || b == bst_pkg::CH_TAB;
    endfunction

    // punctuation kind; two = the two-byte form that starts with b
    function automatic logic [bst_pkg::KIND_W-1:0] punct_kind(input logic [7:0] b,
                                                               input logic two);
        logic [bst_pkg::KIND_W-1:0] k;
        k = bst_pkg::K_INVALID;
        if (two) begin
            case (b)
                bst_pkg::CH_COLON: k = bst_pkg::K_ASSIGN;
                bst_pkg::CH_BANG:  k = bst_pkg::K_NE;
                bst_pkg::CH_EQ:    k = bst_pkg::K_EQEQ;
                bst_pkg::CH_LT:    k = bst_pkg::K_LE;
                bst_pkg::CH_GT:    k = bst_pkg::K_GE;
                bst_pkg::CH_MINUS: k = bst_pkg::K_ARROW;
                default:           k = bst_pkg::K_INVALID;
            endcase
        end else begin
            case (b)
                bst_pkg::CH_DOLLAR: k = bst_pkg::K_DOLLAR;
                bst_pkg::CH_LPAR:   k = bst_pkg::K_LPAR;
                bst_pkg::CH_RPAR:   k = bst_pkg::K_RPAR;
                bst_pkg::CH_STAR:   k = bst_pkg::K_STAR;
                bst_pkg::CH_DOT:    k = bst_pkg::K_DOT;
                bst_pkg::CH_LBRACE: k = bst_pkg::K_LBRACE;
                bst_pkg::CH_RBRACE: k = bst_pkg::K_RBRACE;
                bst_pkg::CH_SEMI:   k = bst_pkg::K_SEMI;
                bst_pkg::CH_COLON:  k = bst_pkg::K_COLON;
                bst_pkg::CH_SLASH:  k = bst_pkg::K_SLASH;
                bst_pkg::CH_PLUS:   k = bst_pkg::K_PLUS;
                bst_pkg::CH_MINUS:  k = bst_pkg::K_MINUS;
                bst_pkg::CH_EQ:     k = bst_pkg::K_EQ;
                bst_pkg::CH_AT:     k = bst_pkg::K_AT;
                bst_pkg::CH_BANG:   k = bst_pkg::K_BANG;
                bst_pkg::CH_LT:     k = bst_pkg::K_LT;
                bst_pkg::CH_GT:     k = bst_pkg::K_GT;
                default:            k = bst_pkg::K_INVALID;
            endcase
        end
        return k;
    endfunction

    function automatic logic [bst_pkg::KIND_W-1:0] held_kind();
        logic [bst_pkg::KIND_W-1:0] k;
        case (cls)
            bst_pkg::CLS_SYMBOL:     k = bst_pkg::K_IDENT;
            bst_pkg::CLS_NUMBER:     k = bst_pkg::K_NUMBER;
            bst_pkg::CLS_STR_OPEN,
            bst_pkg::CLS_STR_DONE:   k = bst_pkg::K_STRING;
            bst_pkg::CLS_COMMENT:    k = bst_pkg::K_COMMENT;
            bst_pkg::CLS_NEWLINE:    k = bst_pkg::K_NEWLINE;
            bst_pkg::CLS_SPACE:      k = bst_pkg::K_SPACE;
            bst_pkg::CLS_TAB:        k = bst_pkg::K_TAB;
            bst_pkg::CLS_TASK_SPACE: k = bst_pkg::K_TASK_SPACE;
            bst_pkg::CLS_TASK_TAB:   k = bst_pkg::K_TASK_TAB;
            bst_pkg::CLS_LIT_OPEN,
            bst_pkg::CLS_LIT_DONE:   k = punct_kind(first_ch, tok_len >= 2);
            default:                 k = bst_pkg::K_INVALID;
        endcase
        return k;
    endfunction

    task automatic clear_text();
        cls       = bst_pkg::CLS_NONE;
        first_ch  = '0;
        tok_start = '0;
        tok_len   = '0;
        tok_line  = bst_pkg::LINE_W'(1);
        tok_col   = '0;
        has_dot   = 1'b0;
        byte_pos  = '0;
        cur_line  = bst_pkg::LINE_W'(1);
        line_base = '0;
        after_nl  = 1'b0;
    endtask

    task automatic queue_token(input logic last_tok);
        t_exp_token t;
        t.kind     = held_kind();
        t.start    = tok_start;
        t.length   = tok_len;
        t.line     = tok_line;
        t.column   = tok_col;
        t.last_tok = last_tok;
        expected_tokens.push_back(t);
    endtask

    // one source byte: extend the held token or close it and open a new one
    task automatic tokenize_byte(input logic [7:0] b, input logic eot);
        logic                      took;
        logic [bst_pkg::POS_W-1:0] col_gap;
        took = 1'b0;
        case (cls)
            bst_pkg::CLS_SYMBOL: took = word_start(b) || decimal(b);
            bst_pkg::CLS_NUMBER: begin
                if (b == bst_pkg::CH_DOT && !has_dot) begin
                    has_dot = 1'b1;
                    took    = 1'b1;
                end else begin
                    took = decimal(b);
                end
            end
            bst_pkg::CLS_STR_OPEN: begin
                took = 1'b1;
                if (b == bst_pkg::CH_QUOTE || b == bst_pkg::CH_NL)
                    cls = bst_pkg::CLS_STR_DONE;
            end
            bst_pkg::CLS_COMMENT: took = (b != bst_pkg::CH_NL);
            bst_pkg::CLS_SPACE, bst_pkg::CLS_TAB,
            bst_pkg::CLS_TASK_SPACE, bst_pkg::CLS_TASK_TAB: took = blank_char(b);
            bst_pkg::CLS_LIT_OPEN: begin
                // '-' pairs with '>', the others with '='
                if (b == ((first_ch == bst_pkg::CH_MINUS) ? bst_pkg::CH_GT
                                                         : bst_pkg::CH_EQ)) begin
                    took = 1'b1;
                    cls  = bst_pkg::CLS_LIT_DONE;
                end
            end
            default: took = 1'b0;
        endcase

        if (took) begin
            if (tok_len != bst_pkg::LEN_MAX)
                tok_len++;
        end else begin
            if (cls != bst_pkg::CLS_NONE)
                queue_token(1'b0);
            col_gap   = byte_pos - line_base;
            tok_start = byte_pos;
            tok_line  = cur_line;
            tok_col   = (col_gap > bst_pkg::LEN_MAX) ? bst_pkg::LEN_MAX
                                                     : col_gap[bst_pkg::LEN_W-1:0];
            tok_len   = bst_pkg::LEN_W'(1);
            first_ch  = b;
            has_dot   = 1'b0;
            if (b == bst_pkg::CH_NL || b == bst_pkg::CH_CR)
                cls = bst_pkg::CLS_NEWLINE;
            else if (blank_char(b))
                cls = after_nl ? ((b == bst_pkg::CH_TAB) ? bst_pkg::CLS_TASK_TAB
                                                         : bst_pkg::CLS_TASK_SPACE)
                               : ((b == bst_pkg::CH_TAB) ? bst_pkg::CLS_TAB
                                                         : bst_pkg::CLS_SPACE);
            else if (word_start(b))
                cls = bst_pkg::CLS_SYMBOL;
            else if (b == bst_pkg::CH_QUOTE)
                cls = bst_pkg::CLS_STR_OPEN;
            else if (decimal(b))
                cls = bst_pkg::CLS_NUMBER;
            else if (punct_kind(b, 1'b1) != bst_pkg::K_INVALID)
                cls = bst_pkg::CLS_LIT_OPEN;
            else if (punct_kind(b, 1'b0) != bst_pkg::K_INVALID)
                cls = bst_pkg::CLS_LIT_DONE;
            else if (b == bst_pkg::CH_HASH)
                cls = bst_pkg::CLS_COMMENT;
            else
                cls = bst_pkg::CLS_INVALID;
        end

        // only '\n' moves the line; '\r' does not
        if (b == bst_pkg::CH_NL) begin
            if (cur_line != bst_pkg::LINE_MAX)
                cur_line++;
            line_base = byte_pos + 1;
        end
        after_nl = (b == bst_pkg::CH_NL);
        byte_pos++;

        if (eot) begin
            queue_token(1'b1);
            clear_text();
        end
    endtask

    task automatic check_token();
        t_exp_token got;
        t_exp_token want;
        got.kind     = i_out_data[5:0];
        got.start    = i_out_data[37:6];
        got.length   = i_out_data[53:38];
        got.line     = i_out_data[77:54];
        got.column   = i_out_data[93:78];
        got.last_tok = i_out_last;
        if (expected_tokens.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
                $display("%0t: unexpected token kind %0d start %0d len %0d line %0d col %0d",
                         $time, got.kind, got.start, got.length, got.line, got.column);
            return;
        end
        want = expected_tokens.pop_front();
        if (got.kind !== want.kind || got.start !== want.start ||
            got.length !== want.length || got.line !== want.line ||
            got.column !== want.column || got.last_tok !== want.last_tok) begin
            fail_count++;
            if (fail_count <= 10) begin
                $display("%0t: token mismatch (kind start len line col last)", $time);
                $display("  expected %0d %0d %0d %0d %0d %0b", want.kind, want.start,
                         want.length, want.line, want.column, want.last_tok);
                $display("  actual   %0d %0d %0d %0d %0d %0b", got.kind, got.start,
                         got.length, got.line, got.column, got.last_tok);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_text();
            expected_tokens.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_token();
            if (i_in_valid && i_in_ready)
                tokenize_byte(i_in_data, i_in_last);
        end
        o_outstanding <= expected_tokens.size();
        o_fail_count  <= fail_count;
    end

endmodule

@@ tb/build_script_tokenizer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// build_script_tokenizer_test
// Feeds source texts to the tokenizer a byte at a time: a directed set of
// short texts, then random texts built from token fragments and noise.
// Both channels stall at random; the checker beside the block predicts and
// compares every token.
// ----------------------------------------------------------------------------
module build_script_tokenizer_test;

    localparam int RANDOM_BYTES   = 430;
    localparam int WATCHDOG_LIMIT = 2000;   // cycles without any handshake
    localparam int TAIL_CYCLES    = 20;     // extra idle cycles after the final drain

    // clock and reset
    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;

    // source byte channel
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;     // [7:0] source_byte
    logic        s_axis_tlast  = 1'b0;   // end_of_text

    // token channel
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;           // [5:0] kind, [37:6] start, [53:38] length,
                                         // [77:54] line, [93:78] column
    logic        m_axis_tlast;           // final_token

    int          fail_count;
    int          outstanding;
    int          quiet_cycles = 0;

    // when set, neither side inserts idle cycles
    logic        no_idle = 1'b0;

    // characters for identifiers: letters and '_' first (indexes 0..52)
    string word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    // every punctuation literal, one- and two-byte forms
    string punct[23] = '{"$", "(", ")", "*", ".", "{", "}", ";", ":=", ":", "/", "+",
                         "-", "!=", "==", "=", "@", "!", "<=", "<", ">=", ">", "->"};

    logic [7:0] text_bytes[$];

    build_script_tokenizer uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    build_script_tokenizer_checker token_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_data     (s_axis_tdata),
        .i_in_last     (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_data    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #6 clk = ~clk;
    end

    // receiver: ready drops in about a third of the cycles
    always @(posedge clk) begin
        m_axis_tready <= no_idle || ($urandom_range(99) >= 34);
    end

    // watchdog: any handshake restarts the count
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one item on the source channel, with a random gap in front
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eot;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic send_text(input string s, input logic eot);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], eot && (i == s.len() - 1));
    endtask

    // hold the source side until every predicted token has left the block
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial begin
        int         sent;
        int         ntok;
        int         pick;
        int         n;
        logic [7:0] b;
        string      lit;

        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed texts ---
        // newline, task space run mixed with tab, comment carrying '\r' and a quote,
        // ended by '\n', number with a second dot, ':=', '->',
        // then byte 0xFF as an invalid token on the final byte
        send_text("\n \t#c\015\"s\n1.2.:= ->", 1'b0);
        send_byte(8'hFF, 1'b1);
        // plain tab run, identifier, unterminated string flushed at text end
        send_text("\tA_9 \"q", 1'b1);
        // NUL alone: state must be back at offset 0, line 1
        send_byte(8'h00, 1'b1);
        // task tab run as the final token
        send_text("x\n\t", 1'b1);
        // '=' not followed by '=', '-' left open at the end
        send_text("=-", 1'b1);

        wait_drained();

        // --- random texts ---
        while (sent < RANDOM_BYTES) begin
            // a stretch in the middle runs with both sides always ready
            no_idle <= (sent >= 150 && sent < 280);
            text_bytes.delete();
            ntok = $urandom_range(1, 8);
            repeat (ntok) begin
                pick = $urandom_range(99);
                if (pick < 15) begin
                    // identifier
                    n = $urandom_range(0, 6);
                    text_bytes.push_back(word_chars[$urandom_range(52)]);
                    repeat (n) text_bytes.push_back(word_chars[$urandom_range(62)]);
                end else if (pick < 27) begin
                    // number, maybe with a fraction
                    n = $urandom_range(1, 4);
                    repeat (n) text_bytes.push_back(8'(8'h30 + $urandom_range(9)));
                    if ($urandom_range(1)) begin
                        text_bytes.push_back(bst_pkg::CH_DOT);
                        n = $urandom_range(0, 3);
                        repeat (n) text_bytes.push_back(8'(8'h30 + $urandom_range(9)));
                    end
                end else if (pick < 37) begin
                    // string with arbitrary body bytes, closed by quote, newline or not
                    text_bytes.push_back(bst_pkg::CH_QUOTE);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == bst_pkg::CH_QUOTE || b == bst_pkg::CH_NL);
                        text_bytes.push_back(b);
                    end
                    pick = $urandom_range(2);
                    if (pick == 0)
                        text_bytes.push_back(bst_pkg::CH_QUOTE);
                    else if (pick == 1)
                        text_bytes.push_back(bst_pkg::CH_NL);
                end else if (pick < 43) begin
                    // comment, ends at the next newline
                    text_bytes.push_back(bst_pkg::CH_HASH);
                    n = $urandom_range(0, 6);
                    repeat (n) begin
                        do
                            b = 8'($urandom_range(255));
                        while (b == bst_pkg::CH_NL);
                        text_bytes.push_back(b);
                    end
                end else if (pick < 57) begin
                    // newline, often followed by indentation
                    pick = $urandom_range(3);
                    if (pick == 0)
                        text_bytes.push_back(bst_pkg::CH_CR);
                    else if (pick == 1) begin
                        text_bytes.push_back(bst_pkg::CH_CR);
                        text_bytes.push_back(bst_pkg::CH_NL);
                    end else
                        text_bytes.push_back(bst_pkg::CH_NL);
                    if ($urandom_range(1)) begin
                        n = $urandom_range(1, 4);
                        repeat (n) text_bytes.push_back($urandom_range(1) ? bst_pkg::CH_TAB
                                                                          : bst_pkg::CH_SPACE);
                    end
                end else if (pick < 68) begin
                    // blank run, spaces and tabs mixed
                    n = $urandom_range(1, 4);
                    repeat (n) text_bytes.push_back($urandom_range(1) ? bst_pkg::CH_TAB
                                                                      : bst_pkg::CH_SPACE);
                end else if (pick < 90) begin
                    lit = punct[$urandom_range(22)];
                    for (int i = 0; i < lit.len(); i++)
                        text_bytes.push_back(lit[i]);
                end else begin
                    // noise byte
                    text_bytes.push_back(8'($urandom_range(255)));
                end
            end
            foreach (text_bytes[i])
                send_byte(text_bytes[i], i == text_bytes.size() - 1);
            sent += text_bytes.size();
        end

        no_idle <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
